FILE: rtl/core/pba_pkg.sv
package pba_pkg;

    localparam int MAX_PAGES_DEF = 16;

    localparam int PB_W       = 25;
    localparam int AL_W       = 17;
    localparam int MASK_W     = 16;
    localparam int ALN_W      = 26;
    localparam int SUM_W      = 27;
    localparam int OFF_OUT_W  = 24;
    localparam int IDX_OUT_W  = 4;
    localparam int STAT_W     = 2;

    localparam logic [PB_W-1:0]  PAGE_MIN    = 25'd256;
    localparam logic [PB_W-1:0]  PAGE_MAX    = 25'd16777216;
    localparam logic [PB_W-1:0]  PAGE_RST    = 25'd65536;
    localparam logic [ALN_W-1:0] FULL_MARGIN = 26'd256;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_TOO_BIG = 2'd1,
        STAT_NO_PAGE = 2'd2
    } t_status;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_RESET = 1'b1
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_SIZE,
        ST_FIT_MAIN,
        ST_MARGIN,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DECIDE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [PB_W-1:0]   base;
        logic [MASK_W-1:0] mask;
        logic [ALN_W-1:0]  addend;
    } t_fit_req;

    typedef struct packed {
        logic [ALN_W-1:0] aligned;
        logic [SUM_W-1:0] sum;
        logic             fit;
    } t_fit_rsp;

endpackage

FILE: rtl/core/pba_fit_unit.sv
module pba_fit_unit import pba_pkg::*; (
    input  logic [PB_W-1:0] i_page_bytes,
    input  t_fit_req        i_req,
    output t_fit_rsp        o_rsp
);

    logic [ALN_W-1:0] mask_ext;
    logic [ALN_W-1:0] aligned;
    logic [SUM_W-1:0] sum;

    always_comb begin
        mask_ext = {{(ALN_W-MASK_W){1'b0}}, i_req.mask};
        aligned  = ({1'b0, i_req.base} + mask_ext) & ~mask_ext;
        sum      = {1'b0, aligned} + {1'b0, i_req.addend};
        o_rsp.aligned = aligned;
        o_rsp.sum     = sum;
        o_rsp.fit     = (sum <= {{(SUM_W-PB_W){1'b0}}, i_page_bytes});
    end

endmodule

FILE: rtl/core/paged_bump_allocator.sv
// Paged bump allocator: carves aligned blocks out of up to MAX_PAGES pages of
// page_bytes bytes, each with its own bump offset held in a small one-port
// offset memory. One item is handled at a time by a sequencer around a single
// align/add/compare unit. An allocate that fits the main page passes the size
// step, which reads the main page offset, and the main-page fit check; an
// oversized request or the very first allocate ends after the size step. A
// miss adds a margin step, then scans the created pages, skipping those not
// available and reading and checking each available one until the first fit,
// and ends with a decision step. A reset-all item clears one page offset per
// cycle. A finished result sits in an output register; the next item is
// accepted only after the result has moved there. The configuration write is
// always ready and clamps page_bytes to 256 .. 16777216.
module paged_bump_allocator import pba_pkg::*; #(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_command,
    input  logic [PB_W-1:0]      i_size_bytes,
    input  logic [AL_W-1:0]      i_alignment,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [STAT_W-1:0]    o_status,
    output logic [IDX_OUT_W-1:0] o_page_index,
    output logic [OFF_OUT_W-1:0] o_byte_offset,
    output logic [PB_W-1:0]      o_granted_bytes,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [PB_W-1:0]      i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_PAGES);
    localparam int CNT_W = $clog2(MAX_PAGES + 1);
    localparam logic [CNT_W-1:0] PAGE_CNT = CNT_W'(MAX_PAGES);

    t_state                r_state, n_state;
    logic [PB_W-1:0]       r_page_bytes;
    logic [PB_W-1:0]       r_size, n_size;
    logic [MASK_W-1:0]     r_mask, n_mask;
    logic [ALN_W-1:0]      r_asize, n_asize;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [CNT_W-1:0]      r_created, n_created;
    logic [IDX_W-1:0]      r_main, n_main;
    logic                  r_main_valid, n_main_valid;
    logic [MAX_PAGES-1:0]  r_avail, n_avail;
    logic [MAX_PAGES-1:0]  r_full, n_full;
    logic                  r_found, n_found;
    logic [IDX_W-1:0]      r_fp, n_fp;
    logic [ALN_W-1:0]      r_fstart, n_fstart;
    logic [SUM_W-1:0]      r_fsum, n_fsum;
    t_status               r_res_status, n_res_status;
    logic [IDX_W-1:0]      r_res_page, n_res_page;
    logic [OFF_OUT_W-1:0]  r_res_off, n_res_off;
    logic [PB_W-1:0]       r_res_grant, n_res_grant;
    logic                  r_out_valid, n_out_valid;
    logic [STAT_W-1:0]     r_out_status, n_out_status;
    logic [IDX_OUT_W-1:0]  r_out_page, n_out_page;
    logic [OFF_OUT_W-1:0]  r_out_off, n_out_off;
    logic [PB_W-1:0]       r_out_grant, n_out_grant;

    logic [PB_W-1:0]       r_mem [MAX_PAGES];
    logic [PB_W-1:0]       r_rdata;
    logic                  mem_we, mem_re;
    logic [IDX_W-1:0]      mem_waddr, mem_raddr;
    logic [PB_W-1:0]       mem_wdata;

    t_fit_req              fit_req;
    t_fit_rsp              fit_rsp;

    logic [MASK_W-1:0]     in_mask;
    logic [MAX_PAGES-1:0]  rst_avail;
    logic [CNT_W-1:0]      last_page;
    logic                  in_acc;
    logic                  out_free;
    logic                  full_main;
    logic                  cm_en;
    logic [IDX_W-1:0]      cm_page;
    logic [ALN_W-1:0]      cm_start;
    logic [SUM_W-1:0]      cm_sum;
    logic [PB_W-1:0]       cfg_val;
    logic [IDX_W+IDX_OUT_W-1:0] page_ext;

    pba_fit_unit u_fit (
        .i_page_bytes (r_page_bytes),
        .i_req        (fit_req),
        .o_rsp        (fit_rsp)
    );

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_page_index    = r_out_page;
    assign o_byte_offset   = r_out_off;
    assign o_granted_bytes = r_out_grant;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign full_main = r_full[r_main];
    assign last_page = r_created - CNT_W'(1);
    assign page_ext  = {{IDX_OUT_W{1'b0}}, r_res_page};

    always_comb begin
        for (int k = 0; k < MASK_W; k++) begin
            in_mask[k] = |(i_alignment >> (k + 1));
        end
        for (int k = 0; k < MAX_PAGES; k++) begin
            rst_avail[k] = (CNT_W'(k) < last_page);
        end
    end

    always_comb begin
        if (i_cfg_data < PAGE_MIN) begin
            cfg_val = PAGE_MIN;
        end else if (i_cfg_data > PAGE_MAX) begin
            cfg_val = PAGE_MAX;
        end else begin
            cfg_val = i_cfg_data;
        end
    end

    always_comb begin
        fit_req.base   = r_rdata;
        fit_req.mask   = r_mask;
        fit_req.addend = r_asize;
        case (r_state)
            ST_SIZE: begin
                fit_req.base   = r_size;
                fit_req.addend = '0;
            end
            ST_MARGIN: begin
                fit_req.mask   = '0;
                fit_req.addend = FULL_MARGIN;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_size       = r_size;
        n_mask       = r_mask;
        n_asize      = r_asize;
        n_idx        = r_idx;
        n_created    = r_created;
        n_main       = r_main;
        n_main_valid = r_main_valid;
        n_avail      = r_avail;
        n_full       = r_full;
        n_found      = r_found;
        n_fp         = r_fp;
        n_fstart     = r_fstart;
        n_fsum       = r_fsum;
        n_res_status = r_res_status;
        n_res_page   = r_res_page;
        n_res_off    = r_res_off;
        n_res_grant  = r_res_grant;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_page   = r_out_page;
        n_out_off    = r_out_off;
        n_out_grant  = r_out_grant;

        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_idx[IDX_W-1:0];
        mem_raddr = r_main;
        mem_wdata = '0;

        cm_en    = 1'b0;
        cm_page  = r_main;
        cm_start = fit_rsp.aligned;
        cm_sum   = fit_rsp.sum;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_size       = i_size_bytes;
                    n_mask       = in_mask;
                    n_res_status = STAT_OK;
                    n_res_page   = '0;
                    n_res_off    = '0;
                    n_res_grant  = '0;
                    n_idx        = '0;
                    if (i_command == CMD_RESET) begin
                        n_state = (r_created == '0) ? ST_DONE : ST_CLR;
                    end else begin
                        n_state = ST_SIZE;
                    end
                end
            end
            ST_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[IDX_W-1:0];
                mem_wdata = '0;
                if (r_idx == last_page) begin
                    n_full       = '0;
                    n_avail      = rst_avail;
                    n_main       = last_page[IDX_W-1:0];
                    n_main_valid = 1'b1;
                    n_state      = ST_DONE;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            ST_SIZE: begin
                n_asize = fit_rsp.aligned;
                if (!fit_rsp.fit) begin
                    n_res_status = STAT_TOO_BIG;
                    n_state      = ST_DONE;
                end else if (!r_main_valid) begin
                    if (r_created == PAGE_CNT) begin
                        n_res_status = STAT_NO_PAGE;
                    end else begin
                        cm_en        = 1'b1;
                        cm_page      = r_created[IDX_W-1:0];
                        cm_start     = '0;
                        cm_sum       = {1'b0, fit_rsp.aligned};
                        n_main       = r_created[IDX_W-1:0];
                        n_main_valid = 1'b1;
                        n_created    = r_created + CNT_W'(1);
                    end
                    n_state = ST_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_main;
                    n_state   = ST_FIT_MAIN;
                end
            end
            ST_FIT_MAIN: begin
                if (fit_rsp.fit) begin
                    cm_en   = 1'b1;
                    cm_page = r_main;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MARGIN;
                end
            end
            ST_MARGIN: begin
                if (!fit_rsp.fit) begin
                    n_full[r_main] = 1'b1;
                end
                n_idx   = '0;
                n_found = 1'b0;
                n_state = ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                if (r_idx >= r_created) begin
                    n_state = ST_DECIDE;
                end else if (r_avail[r_idx[IDX_W-1:0]]) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx[IDX_W-1:0];
                    n_state   = ST_SCAN_CHK;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            ST_SCAN_CHK: begin
                if (fit_rsp.fit) begin
                    n_found  = 1'b1;
                    n_fp     = r_idx[IDX_W-1:0];
                    n_fstart = fit_rsp.aligned;
                    n_fsum   = fit_rsp.sum;
                    n_state  = ST_DECIDE;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = ST_SCAN_RD;
                end
            end
            ST_DECIDE: begin
                if (r_found) begin
                    if (!full_main) begin
                        n_avail[r_fp] = 1'b0;
                        n_main        = r_fp;
                    end
                    cm_en    = 1'b1;
                    cm_page  = r_fp;
                    cm_start = r_fstart;
                    cm_sum   = r_fsum;
                end else if (r_created == PAGE_CNT) begin
                    n_res_status = STAT_NO_PAGE;
                end else begin
                    if (!full_main) begin
                        n_main = r_created[IDX_W-1:0];
                    end
                    cm_en     = 1'b1;
                    cm_page   = r_created[IDX_W-1:0];
                    cm_start  = '0;
                    cm_sum    = {1'b0, r_asize};
                    n_created = r_created + CNT_W'(1);
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_page   = page_ext[IDX_OUT_W-1:0];
                    n_out_off    = r_res_off;
                    n_out_grant  = r_res_grant;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (cm_en) begin
            mem_we       = 1'b1;
            mem_waddr    = cm_page;
            mem_wdata    = cm_sum[PB_W-1:0];
            n_res_status = STAT_OK;
            n_res_page   = cm_page;
            n_res_off    = (cm_start[ALN_W-1:OFF_OUT_W] != '0) ? '1
                                                              : cm_start[OFF_OUT_W-1:0];
            n_res_grant  = r_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_page_bytes <= PAGE_RST;
            r_created    <= '0;
            r_main       <= '0;
            r_main_valid <= 1'b0;
            r_avail      <= '0;
            r_full       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_created    <= n_created;
            r_main       <= n_main;
            r_main_valid <= n_main_valid;
            r_avail      <= n_avail;
            r_full       <= n_full;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_page_bytes <= cfg_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_size       <= n_size;
        r_mask       <= n_mask;
        r_asize      <= n_asize;
        r_idx        <= n_idx;
        r_found      <= n_found;
        r_fp         <= n_fp;
        r_fstart     <= n_fstart;
        r_fsum       <= n_fsum;
        r_res_status <= n_res_status;
        r_res_page   <= n_res_page;
        r_res_off    <= n_res_off;
        r_res_grant  <= n_res_grant;
        r_out_status <= n_out_status;
        r_out_page   <= n_out_page;
        r_out_off    <= n_out_off;
        r_out_grant  <= n_out_grant;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

endmodule

FILE: rtl/core/pba_checker.sv
module pba_checker import pba_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 i_command,
    input logic [PB_W-1:0]      i_size_bytes,
    input logic [AL_W-1:0]      i_alignment,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [STAT_W-1:0]    o_status,
    input logic [IDX_OUT_W-1:0] o_page_index,
    input logic [OFF_OUT_W-1:0] o_byte_offset,
    input logic [PB_W-1:0]      o_granted_bytes,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready,
    input logic [PB_W-1:0]      i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_page_index) && $stable(o_byte_offset) && $stable(o_granted_bytes))
        else $error("result item changed while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != STAT_OK) |->
            (o_page_index == '0) && (o_byte_offset == '0) && (o_granted_bytes == '0))
        else $error("failed item carries nonzero fields");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("item accepted while previous item in flight");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind paged_bump_allocator pba_checker u_pba_checker (.*);

FILE: tb/paged_bump_allocator_tb.sv
module paged_bump_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pba_pkg::*;

    localparam int NPAGES = MAX_PAGES_DEF;
    localparam int SETTLE = 5 + 2 * NPAGES + 8;
    localparam int LIMIT  = 400000;
    localparam int DRAIN  = 20000;

    typedef struct packed {
        t_cmd            cmd;
        logic [PB_W-1:0] size;
        logic [AL_W-1:0] aln;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [IDX_OUT_W-1:0] page;
        logic [OFF_OUT_W-1:0] offset;
        logic [PB_W-1:0]      granted;
    } t_grant;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 i_command = 1'b0;
    logic [PB_W-1:0]      i_size_bytes = '0;
    logic [AL_W-1:0]      i_alignment = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [PB_W-1:0]      i_cfg_data = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [STAT_W-1:0]    o_status;
    logic [IDX_OUT_W-1:0] o_page_index;
    logic [OFF_OUT_W-1:0] o_byte_offset;
    logic [PB_W-1:0]      o_granted_bytes;
    logic                 o_cfg_ready;

    paged_bump_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_size_bytes    (i_size_bytes),
        .i_alignment     (i_alignment),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_page_index    (o_page_index),
        .o_byte_offset   (o_byte_offset),
        .o_granted_bytes (o_granted_bytes),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_req   req_q[$];
    t_grant grant_q[$];
    t_req   cur_req;
    bit     steady = 1'b0;

    logic [PB_W-1:0] pg_bytes = PAGE_RST;
    logic [PB_W-1:0] pool_off [NPAGES];
    bit              pool_full [NPAGES];
    int unsigned     pool_count = 0;
    int unsigned     home = 0;
    bit              home_ok = 1'b0;
    logic [NPAGES-1:0] spare = '0;

    int unsigned cycles = 0;
    int unsigned errors = 0;
    int unsigned n_sent = 0;
    int unsigned n_resets = 0;
    int unsigned n_cfg = 0;
    int unsigned n_ok = 0;
    int unsigned n_big = 0;
    int unsigned n_full = 0;

    function automatic longint unsigned round_up(longint unsigned x, longint unsigned a);
        return (x + a - 1) & ~(a - 1);
    endfunction

    function automatic bit room_for(int p, longint unsigned need, longint unsigned a);
        longint unsigned cap;
        cap = pg_bytes;
        return round_up(pool_off[p], a) + need <= cap;
    endfunction

    function automatic int first_spare(longint unsigned need, longint unsigned a);
        for (int i = 0; i < NPAGES && i < pool_count; i++)
            if (spare[i] && room_for(i, need, a))
                return i;
        return -1;
    endfunction

    function automatic int open_page();
        int p;
        if (pool_count >= NPAGES)
            return -1;
        p = pool_count;
        pool_count++;
        pool_off[p] = '0;
        pool_full[p] = 1'b0;
        return p;
    endfunction

    function automatic t_grant allocate(t_req r);
        t_grant g;
        longint unsigned a, need, start, rem, cap, used;
        int p;
        g = '0;
        g.status = STAT_OK;
        a = 1;
        for (int b = AL_W - 1; b >= 0; b--)
            if (r.aln[b]) begin
                a = 64'd1 << b;
                break;
            end
        if (r.cmd == CMD_RESET) begin
            if (pool_count == 0)
                return g;
            spare = '0;
            for (int i = 0; i < NPAGES && i < pool_count; i++) begin
                pool_off[i] = '0;
                pool_full[i] = 1'b0;
                spare[i] = 1'b1;
            end
            home = (pool_count < NPAGES ? pool_count : NPAGES) - 1;
            spare[home] = 1'b0;
            home_ok = 1'b1;
            return g;
        end
        cap = pg_bytes;
        need = round_up(r.size, a);
        if (need > cap) begin
            g.status = STAT_TOO_BIG;
            return g;
        end
        if (!home_ok) begin
            p = open_page();
            if (p < 0) begin
                g.status = STAT_NO_PAGE;
                return g;
            end
            home = p;
            home_ok = 1'b1;
        end
        p = home;
        if (!room_for(p, need, a)) begin
            used = pool_off[p];
            rem = (used >= cap) ? 0 : cap - used;
            if (rem < FULL_MARGIN)
                pool_full[p] = 1'b1;
            p = first_spare(need, a);
            if (!pool_full[home]) begin
                if (p >= 0) begin
                    spare[p] = 1'b0;
                end else begin
                    p = open_page();
                    if (p < 0) begin
                        g.status = STAT_NO_PAGE;
                        return g;
                    end
                end
                home = p;
            end else if (p < 0) begin
                p = open_page();
                if (p < 0) begin
                    g.status = STAT_NO_PAGE;
                    return g;
                end
            end
        end
        start = round_up(pool_off[p], a);
        pool_off[p] = PB_W'(start + need);
        g.page = IDX_OUT_W'(p);
        g.offset = (start > 64'hFFFFFF) ? 24'hFFFFFF : OFF_OUT_W'(start);
        g.granted = r.size;
        return g;
    endfunction

    task automatic flag(string what, longint unsigned got, longint unsigned want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic push(t_cmd cmd, logic [PB_W-1:0] size, logic [AL_W-1:0] aln);
        req_q.push_back('{cmd, size, aln});
    endtask

    task automatic add_random(int count);
        t_req r;
        int unsigned pick;
        for (int k = 0; k < count; k++) begin
            r.cmd = ($urandom_range(99) < 4) ? CMD_RESET : CMD_ALLOC;
            pick = $urandom_range(99);
            if (pick < 60)
                r.aln = 17'd1 << $urandom_range(4);
            else if (pick < 85)
                r.aln = 17'd1 << $urandom_range(AL_W - 1);
            else if (pick < 95)
                r.aln = AL_W'($urandom);
            else
                r.aln = '0;
            pick = $urandom_range(99);
            if (pick < 45)
                r.size = PB_W'($urandom_range(pg_bytes / 16));
            else if (pick < 65)
                r.size = PB_W'($urandom_range(pg_bytes));
            else if (pick < 80)
                r.size = PB_W'($urandom_range(300));
            else if (pick < 90)
                r.size = PB_W'(pg_bytes - $urandom_range(255));
            else
                r.size = PB_W'($urandom);
            req_q.push_back(r);
        end
    endtask

    task automatic write_page_size(logic [PB_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        pg_bytes = (v < PAGE_MIN) ? PAGE_MIN : ((v > PAGE_MAX) ? PAGE_MAX : v);
        n_cfg++;
    endtask

    task automatic settle();
        int n;
        n = 0;
        while ((req_q.size() != 0 || i_in_valid || grant_q.size() != 0) && n < DRAIN) begin
            @(negedge i_clk);
            n++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        bit load;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                grant_q.push_back(allocate(cur_req));
                n_sent++;
                if (cur_req.cmd == CMD_RESET)
                    n_resets++;
            end
            load = (!i_in_valid || o_in_ready) && req_q.size() != 0
                   && (steady || $urandom_range(99) >= 14);
            if (load) begin
                cur_req = req_q.pop_front();
                i_command <= cur_req.cmd;
                i_size_bytes <= cur_req.size;
                i_alignment <= cur_req.aln;
                i_in_valid <= 1'b1;
            end else if (!i_in_valid || o_in_ready) begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (grant_q.size() == 0) begin
                    flag("result with no item pending", o_status, 0);
                end else begin
                    want = grant_q.pop_front();
                    case (want.status)
                        STAT_OK:      n_ok++;
                        STAT_TOO_BIG: n_big++;
                        default:      n_full++;
                    endcase
                    if (o_status !== want.status)
                        flag("status", o_status, want.status);
                    if (o_page_index !== want.page)
                        flag("page_index", o_page_index, want.page);
                    if (o_byte_offset !== want.offset)
                        flag("byte_offset", o_byte_offset, want.offset);
                    if (o_granted_bytes !== want.granted)
                        flag("granted_bytes", o_granted_bytes, want.granted);
                end
            end
            i_out_ready <= steady || $urandom_range(99) >= 14;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push(CMD_RESET, 25'h1FFFFFF, 17'h1FFFF);
        push(CMD_ALLOC, 25'd0, 17'd0);
        push(CMD_ALLOC, 25'd100, 17'd3);
        push(CMD_ALLOC, 25'd16, 17'd65536);
        push(CMD_ALLOC, 25'd65537, 17'd1);
        push(CMD_ALLOC, 25'h1FFFFFF, 17'h1FFFF);
        push(CMD_ALLOC, 25'd65536, 17'd1);
        push(CMD_ALLOC, 25'd200, 17'd1);
        settle();

        write_page_size('0);
        repeat (15) push(CMD_ALLOC, 25'd256, 17'd1);
        settle();

        write_page_size(25'h1FFFFFF);
        push(CMD_RESET, 25'd0, 17'd1);
        push(CMD_ALLOC, 25'd16777216, 17'd1);
        push(CMD_ALLOC, 25'd0, 17'd1);
        settle();

        write_page_size(25'd4096);
        push(CMD_ALLOC, 25'd64, 17'd8);
        settle();

        write_page_size(25'd65536);
        add_random(100);
        settle();

        write_page_size(PB_W'($urandom_range(256, 8192)));
        add_random(100);
        settle();

        write_page_size(25'd16777216);
        steady <= 1'b1;
        add_random(100);
        settle();
        steady <= 1'b0;

        write_page_size(25'd100);
        add_random(100);
        settle();

        write_page_size(PB_W'($urandom));
        add_random(100);
        settle();

        if (grant_q.size() != 0)
            flag("results still outstanding", grant_q.size(), 0);
        $display("covered: %0d items (%0d pool resets) over %0d page size settings",
                 n_sent, n_resets, n_cfg);
        $display("outcomes: %0d granted, %0d oversized, %0d pool exhausted",
                 n_ok, n_big, n_full);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: paged_bump_allocator.f
rtl/core/pba_pkg.sv
rtl/core/pba_fit_unit.sv
rtl/core/paged_bump_allocator.sv
rtl/core/pba_checker.sv
tb/paged_bump_allocator_tb.sv
